// ===== design/rssd_pkg.sv =====
package rssd_pkg;

	// register indexes on the configuration port
	localparam logic CFG_SPRITE_WIDTH = 1'b0;
	localparam logic CFG_COLOR_KEY    = 1'b1;

	// default depth of the pixel queue between front and back
	localparam int FIFO_DEPTH_DEF = 4;

	// one colored pixel, handed from the parser to the converter
	typedef struct packed {
		logic [15:0] column;
		logic [15:0] pixel;
	} pixel_req_t;

	// queue status seen by the back and by the input handshake
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ===== design/rle_sprite_scanline_decoder_unit.sv =====
// RLE sprite scanline decoder, RGB565 source to RGBA32 pixel writes.
// Input stream: s_tdata carries one 16-bit RLE word, s_tuser marks the
// segment-count word that opens a scanline. Words are taken whenever the
// pixel queue has room, one per cycle.
// Output stream: one request per coloured pixel, m_tdata = column in
// bits 15-0 and RGBA32 in bits 47-16 (R 23-16, G 31-24, B 39-32, A 47-40).
// Configuration: cfg_we writes cfg_data into register cfg_addr
// (0 sprite width, 1 colour key); write only while the block is idle.
// Throughput is one word per cycle while the queue has room.
// Accepted pixel words go through the queue and the output register.
// When the receiver stalls, the output register holds its request and the
// queue of FIFO_DEPTH entries fills; s_tready drops only once it is full.
// Reset clears the parser to expect a segment count, empties the queue and
// sets both registers to zero.
module rle_sprite_scanline_decoder_unit
	import rssd_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rle_word
	input  logic        s_tuser,   // line_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // column [15:0], rgba_value [47:16]
);

	logic [15:0] width_q;
	logic [15:0] key_q;
	logic        push;
	logic        pop;
	pixel_req_t  push_data;
	pixel_req_t  head;
	fifo_stat_t  stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 16'd0;
			key_q   <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_SPRITE_WIDTH: width_q <= cfg_data;
				CFG_COLOR_KEY:    key_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	assign s_tready = !stat.full;

	rssd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (s_tvalid && s_tready),
		.rle_word     (s_tdata),
		.line_start   (s_tuser),
		.sprite_width (width_q),
		.push         (push),
		.push_data    (push_data)
	);

	rssd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	rssd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.stat      (stat),
		.color_key (key_q),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== design/rssd_front.sv =====
module rssd_front
	import rssd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             word_valid,
	input  logic [15:0]      rle_word,
	input  logic             line_start,
	input  logic [15:0]      sprite_width,
	output logic             push,
	output pixel_req_t       push_data
);

	typedef enum logic [3:0] {
		PH_COUNT = 4'b0001,
		PH_TRANS = 4'b0010,
		PH_CLEN  = 4'b0100,
		PH_PIXEL = 4'b1000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] segs_q, segs_d;
	logic [15:0] clen_q, clen_d;
	logic [16:0] col_q, col_d;

	logic [16:0] col_add;
	logic [16:0] col_inc;
	logic [15:0] seg_dec;
	logic [15:0] clen_dec;
	logic        width_zero;

	assign col_add    = col_q + {1'b0, rle_word};
	assign col_inc    = col_q + 17'd1;
	assign seg_dec    = segs_q - 16'd1;
	assign clen_dec   = clen_q - 16'd1;
	assign width_zero = (sprite_width == 16'd0);

	// pixel words go to the queue with their column
	assign push             = word_valid && !line_start && (phase_q == PH_PIXEL);
	assign push_data.column = col_q[15:0];
	assign push_data.pixel  = rle_word;

	// parse one word
	always_comb begin
		phase_d = phase_q;
		segs_d  = segs_q;
		clen_d  = clen_q;
		col_d   = col_q;
		if (line_start) begin
			col_d   = 17'd0;
			segs_d  = rle_word;
			clen_d  = 16'd0;
			phase_d = (rle_word == 16'd0 || width_zero) ? PH_COUNT : PH_TRANS;
		end else begin
			case (phase_q)
				PH_TRANS: begin
					col_d   = col_add;
					phase_d = (col_add >= {1'b0, sprite_width}) ? PH_COUNT : PH_CLEN;
				end
				PH_CLEN: begin
					if (rle_word == 16'd0) begin
						segs_d  = seg_dec;
						phase_d = (seg_dec == 16'd0) ? PH_COUNT : PH_TRANS;
					end else begin
						clen_d  = rle_word;
						phase_d = PH_PIXEL;
					end
				end
				PH_PIXEL: begin
					col_d  = col_inc;
					clen_d = clen_dec;
					if (col_inc >= {1'b0, sprite_width}) begin
						phase_d = PH_COUNT;
					end else if (clen_dec == 16'd0) begin
						segs_d  = seg_dec;
						phase_d = (seg_dec == 16'd0) ? PH_COUNT : PH_TRANS;
					end
				end
				default: begin
					phase_d = PH_COUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			segs_q  <= 16'd0;
			clen_q  <= 16'd0;
			col_q   <= 17'd0;
		end else if (word_valid) begin
			phase_q <= phase_d;
			segs_q  <= segs_d;
			clen_q  <= clen_d;
			col_q   <= col_d;
		end
	end

endmodule

// ===== design/rssd_fifo.sv =====
module rssd_fifo
	import rssd_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pixel_req_t push_data,
	input  logic       pop,
	output pixel_req_t head,
	output fifo_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	pixel_req_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/rssd_back.sv =====
module rssd_back
	import rssd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  pixel_req_t  head,
	input  fifo_stat_t  stat,
	input  logic [15:0] color_key,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata
);

	logic [4:0]  r5, b5;
	logic [5:0]  g6;
	logic [31:0] rgba;

	// RGB565 to RGBA32 by bit replication, colour key gives zero
	assign r5 = head.pixel[15:11];
	assign g6 = head.pixel[10:5];
	assign b5 = head.pixel[4:0];
	assign rgba = (head.pixel == color_key) ? 32'd0 :
		{8'hFF, b5, b5[4:2], g6, g6[5:4], r5, r5[4:2]};

	assign pop = !stat.empty && (!m_tvalid || m_tready);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= !stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata <= {rgba, head.column};
		end
	end

endmodule

// ===== verif/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rssd_pkg::*;

	// parser position within a scanline
	typedef enum logic [1:0] {
		WANT_COUNT,
		WANT_TRANS,
		WANT_CLEN,
		WANT_PIXEL
	} parse_phase_t;

	typedef struct {
		logic [15:0] word;
		logic        start;
	} rle_req_t;

	typedef struct {
		logic [15:0] column;
		logic [31:0] rgba;
	} pixel_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_addr = CFG_SPRITE_WIDTH;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;     // rle_word
	logic        s_tuser = 1'b0;   // line_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;          // column [15:0], rgba_value [47:16]

	rle_sprite_scanline_decoder_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// words waiting to be offered, pixel writes still owed by the block
	rle_req_t     rle_words_pending[$];
	pixel_write_t pixel_writes_due[$];
	rle_req_t     next_word;
	pixel_write_t got_write;

	// decoder state as the block should hold it
	parse_phase_t phase = WANT_COUNT;
	logic [15:0]  segs_left = '0;
	logic [15:0]  run_left = '0;
	logic [16:0]  col_pos = '0;
	logic [15:0]  cfg_width = '0;
	logic [15:0]  cfg_key = '0;

	int  errors = 0;
	int  tx_idle_pct = 0;
	int  rx_idle_pct = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	bit  word_taken = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// segment done: next transparent run or back to waiting for a line
	task automatic close_segment();
		segs_left = segs_left - 16'd1;
		phase = (segs_left == 16'd0) ? WANT_COUNT : WANT_TRANS;
	endtask

	// advance the decoder by one accepted word, noting any pixel write owed
	task automatic decode_word(input logic [15:0] w, input logic start);
		pixel_write_t pw;
		if (start) begin
			col_pos = '0;
			segs_left = w;
			run_left = '0;
			phase = (w == 16'd0 || cfg_width == 16'd0) ? WANT_COUNT : WANT_TRANS;
		end else begin
			case (phase)
				WANT_TRANS: begin
					col_pos = col_pos + {1'b0, w};
					phase = (col_pos >= {1'b0, cfg_width}) ? WANT_COUNT : WANT_CLEN;
				end
				WANT_CLEN: begin
					if (w == 16'd0) begin
						close_segment();
					end else begin
						run_left = w;
						phase = WANT_PIXEL;
					end
				end
				WANT_PIXEL: begin
					pw.column = col_pos[15:0];
					// 5/6-bit replication, keyed colour goes fully transparent
					if (w == cfg_key)
						pw.rgba = '0;
					else
						pw.rgba = {8'hFF, w[4:0], w[4:2], w[10:5], w[10:9],
							w[15:11], w[15:13]};
					pixel_writes_due.push_back(pw);
					col_pos = col_pos + 17'd1;
					run_left = run_left - 16'd1;
					if (col_pos >= {1'b0, cfg_width})
						phase = WANT_COUNT;
					else if (run_left == 16'd0)
						close_segment();
				end
				default: ;
			endcase
		end
	endtask

	task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
		errors++;
		$display("%0t: %s expected %h, got %h", $time, what, want, got);
	endtask

	// monitor: predict on each accepted word, check each accepted pixel write
	always @(posedge clk) begin
		word_taken = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				word_taken = 1'b1;
				decode_word(s_tdata, s_tuser);
			end
			if (m_tvalid && m_tready) begin
				if (pixel_writes_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected request, expected none, got %h",
						$time, m_tdata);
				end else begin
					got_write = pixel_writes_due.pop_front();
					if (m_tdata[15:0] !== got_write.column)
						flag("column", {16'd0, got_write.column}, {16'd0, m_tdata[15:0]});
					if (m_tdata[47:16] !== got_write.rgba)
						flag("rgba", got_write.rgba, m_tdata[47:16]);
				end
			end
		end
	end

	// driver: hold a word until taken, then offer the next or idle
	always @(negedge clk) begin
		if (!s_tvalid || word_taken) begin
			if (rle_words_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				next_word = rle_words_pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= next_word.word;
				s_tuser  <= next_word.start;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic write_reg(input logic idx, input logic [15:0] v);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= v;
		if (idx == CFG_SPRITE_WIDTH)
			cfg_width = v;
		else
			cfg_key = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_word(input logic [15:0] w, input logic start);
		rle_req_t r;
		r.word = w;
		r.start = start;
		rle_words_pending.push_back(r);
	endtask

	// everything offered and delivered, then let trailing words settle
	task automatic wait_idle();
		while (rle_words_pending.size() != 0 || s_tvalid || pixel_writes_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// one scanline with random content; a few are cut short or announce more segments than follow
	task automatic queue_scanline();
		int nseg;
		int r;
		int s;
		int p;
		int clen;
		r = $urandom_range(99);
		nseg = (r < 5) ? 0 : (r < 9) ? $urandom_range(65535) : $urandom_range(1, 5);
		add_word(nseg[15:0], 1'b1);
		for (s = 0; s < nseg && s < 6; s++) begin
			if ($urandom_range(99) < 3)
				return;
			if ($urandom_range(99) < 10)
				add_word(16'($urandom_range(65535)), 1'b0);
			else
				add_word(16'($urandom_range(6)), 1'b0);
			clen = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 8);
			add_word(clen[15:0], 1'b0);
			for (p = 0; p < clen; p++) begin
				if ($urandom_range(99) < 2)
					return;
				if ($urandom_range(99) < 15)
					add_word(cfg_key, 1'b0);
				else
					add_word(16'($urandom_range(65535)), 1'b0);
			end
		end
	endtask

	int          round;
	logic [15:0] round_width[6] = '{16'd40, 16'd65535, 16'd23, 16'd1, 16'd300, 16'd128};

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 32;
		rx_idle_pct = 60;

		// directed: width 16, key pure red
		write_reg(CFG_SPRITE_WIDTH, 16'd16);
		write_reg(CFG_COLOR_KEY, 16'hF800);
		add_word(16'd5, 1'b0);       // outside a line, ignored
		add_word(16'd3, 1'b1);
		add_word(16'd0, 1'b0);
		add_word(16'd2, 1'b0);
		add_word(16'hFFFF, 1'b0);
		add_word(16'h0000, 1'b0);
		add_word(16'd3, 1'b0);
		add_word(16'd0, 1'b0);       // empty colour run
		add_word(16'd1, 1'b0);
		add_word(16'd3, 1'b0);
		add_word(16'hF800, 1'b0);    // keyed pixel
		add_word(16'd2, 1'b1);       // restart mid-line
		add_word(16'hFFFF, 1'b0);    // transparent run overruns the width
		add_word(16'h1234, 1'b0);
		add_word(16'd0, 1'b1);       // no segments
		add_word(16'd7, 1'b0);
		add_word(16'hFFFF, 1'b1);
		add_word(16'd14, 1'b0);
		add_word(16'd5, 1'b0);
		add_word(16'h07E0, 1'b0);
		add_word(16'h001F, 1'b0);    // reaches the width, clipped
		add_word(16'hABCD, 1'b0);
		add_word(16'd1, 1'b1);
		add_word(16'd0, 1'b0);
		add_word(16'd1, 1'b0);       // line left waiting for its pixel
		wait_idle();

		// zero width and a new key while the line above is still open
		write_reg(CFG_SPRITE_WIDTH, 16'd0);
		write_reg(CFG_COLOR_KEY, 16'hFFFF);
		add_word(16'hFFFF, 1'b0);
		add_word(16'd3, 1'b1);
		add_word(16'd0, 1'b0);
		add_word(16'd2, 1'b0);
		add_word(16'hAAAA, 1'b0);
		wait_idle();

		// random scanlines over a range of widths and keys
		for (round = 0; round < 6; round++) begin
			if (round < 2) begin
				tx_idle_pct = 32;
				rx_idle_pct = 60;
			end else if (round < 4) begin
				tx_idle_pct = 60;
				rx_idle_pct = 32;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_reg(CFG_SPRITE_WIDTH, round_width[round]);
			write_reg(CFG_COLOR_KEY, (round == 0) ? 16'h0000 :
				(round == 1) ? 16'hFFFF : 16'($urandom_range(65535)));
			while (rle_words_pending.size() < 112) begin
				if ($urandom_range(99) < 6)
					add_word(16'($urandom_range(65535)), 1'($urandom_range(1)));
				else
					queue_scanline();
			end
			if (round == 4) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			wait_idle();
		end

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
